// ===== sv/huffman_code_bit_packer_unit_defines.svh =====
// Assertion macros for the Huffman code bit packer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH

`ifndef SYNTH
// check while out of reset
`define HCBP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// check at every edge, reset included
`define HCBP_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HCBP_ASSERT(lbl, clk, rstn, prop, msg)
`define HCBP_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/hcbp_pkg.sv =====
// Shared types and constants for the Huffman code bit packer.
// No dependencies; imported by every module of the block.
package hcbp_pkg;

  localparam int SYMBOLS_DEF      = 256;
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int CODE_W           = 32;
  localparam int LEN_W            = 6;
  localparam int BYTE_W           = 8;
  localparam int TOTAL_W          = 32;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } hcbp_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic [TOTAL_W-1:0] total_bits;
    logic               last;
  } hcbp_out_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } hcbp_entry_t;

  typedef struct packed {
    logic              start_enc;
    logic              start_flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } hcbp_pk_ctrl_t;

  typedef struct packed {
    logic busy;
  } hcbp_pk_status_t;

endpackage

// ===== sv/hcbp_table.sv =====
// Code table: one synchronous memory of code bits and lengths, one entry per symbol.
// Uses hcbp_pkg; read data is registered, no reset.
module hcbp_table #(
  parameter int SYMBOLS = hcbp_pkg::SYMBOLS_DEF,
  parameter int ADDR_W  = $clog2(SYMBOLS)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  hcbp_pkg::hcbp_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output hcbp_pkg::hcbp_entry_t rd_data
);
  import hcbp_pkg::*;

  hcbp_entry_t mem [SYMBOLS];
  hcbp_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/hcbp_packer.sv =====
// Bit packer: appends a left-aligned code to the pending byte, one byte step a cycle
// when not stalled, and emits bytes and flush results through an output register. Uses hcbp_pkg.
`include "huffman_code_bit_packer_unit_defines.svh"
module hcbp_packer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hcbp_pkg::hcbp_pk_ctrl_t   ctrl,
  output hcbp_pkg::hcbp_pk_status_t status,
  output logic                      out_valid,
  input  logic                      out_stall,
  output hcbp_pkg::hcbp_out_t       out_data
);
  import hcbp_pkg::*;

  typedef enum logic [1:0] {P_IDLE, P_ENC, P_FLUSH} pstate_t;

  pstate_t            pstate_r;
  logic [CODE_W-1:0]  code_al_r;
  logic [LEN_W-1:0]   n_r;
  logic [BYTE_W-1:0]  pend_r;
  logic [2:0]         fill_r;
  logic [TOTAL_W-1:0] total_r;
  logic               out_valid_r;
  hcbp_out_t          out_data_r;

  logic               out_free;
  logic               emit;
  logic [3:0]         room;
  logic [3:0]         take;
  logic [LEN_W-1:0]   n_nxt;
  logic [3:0]         fill_sum;
  logic [BYTE_W-1:0]  pend_nxt;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_nxt;

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    room      = 4'(BYTE_W) - {1'b0, fill_r};
    take      = (n_r < {2'b00, room}) ? n_r[3:0] : room;
    n_nxt     = n_r - {2'b00, take};
    fill_sum  = {1'b0, fill_r} + take;
    pend_nxt  = pend_r | (code_al_r[CODE_W-1 -: BYTE_W] >> fill_r);
    sum       = {1'b0, total_r} + (TOTAL_W+1)'(take);
    total_nxt = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    emit      = out_free && (((pstate_r == P_ENC) && fill_sum[3]) || (pstate_r == P_FLUSH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pstate_r    <= P_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= '0;
      fill_r      <= '0;
      total_r     <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (pstate_r)
        P_IDLE: begin
          if (ctrl.start_flush) begin
            pstate_r <= P_FLUSH;
          end else if (ctrl.start_enc && (ctrl.len != '0)) begin
            // left-align so the next bits to send always sit at the top
            code_al_r <= ctrl.code << (LEN_W'(CODE_W) - ctrl.len);
            n_r       <= ctrl.len;
            pstate_r  <= P_ENC;
          end
        end
        P_ENC: begin
          if (out_free) begin
            code_al_r <= code_al_r << take;
            n_r       <= n_nxt;
            total_r   <= total_nxt;
            if (fill_sum[3]) begin
              out_data_r.out_byte   <= pend_nxt;
              out_data_r.byte_valid <= 1'b1;
              out_data_r.total_bits <= total_nxt;
              // fewer than a byte left: no further byte from this word
              out_data_r.last       <= (n_nxt < LEN_W'(BYTE_W));
              pend_r                <= '0;
              fill_r                <= '0;
            end else begin
              pend_r <= pend_nxt;
              fill_r <= fill_sum[2:0];
            end
            if (n_nxt == '0) begin
              pstate_r <= P_IDLE;
            end
          end
        end
        P_FLUSH: begin
          if (out_free) begin
            out_data_r.out_byte   <= (fill_r != '0) ? pend_r : '0;
            out_data_r.byte_valid <= (fill_r != '0);
            out_data_r.total_bits <= total_r;
            out_data_r.last       <= 1'b1;
            pend_r                <= '0;
            fill_r                <= '0;
            total_r               <= '0;
            pstate_r              <= P_IDLE;
          end
        end
        default: pstate_r <= P_IDLE;
      endcase
    end
  end

  assign status.busy = (pstate_r != P_IDLE);
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  `HCBP_ASSERT(a_enc_has_bits, clk, rst_n, (pstate_r == P_ENC) |-> (n_r != '0), "encode step with no bits left")
  `HCBP_ASSERT(a_empty_pend_zero, clk, rst_n, (fill_r == '0) |-> (pend_r == '0), "stale bits in empty pending byte")
  `HCBP_ASSERT(a_start_when_idle, clk, rst_n, (ctrl.start_enc || ctrl.start_flush) |-> (pstate_r == P_IDLE), "packer started while busy")
  `HCBP_ASSERT_RST(a_reset_clears_out, clk, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

// ===== sv/huffman_code_bit_packer_unit.sv =====
// Top level of the Huffman code bit packer: handshake, command decode and table access.
// Uses hcbp_pkg, hcbp_table and hcbp_packer.
//
//   channel  dir  handshake             payload
//   in       in   in_valid / in_stall    hcbp_in_t  (cmd, symbol, code_bits, code_length)
//   out      out  out_valid / out_stall  hcbp_out_t (out_byte, byte_valid, total_bits, last)
//
// Load is a table write. Encode reads the table (registered), then starts the packer, which
// takes one byte step a cycle while out is not stalled: up to 5 for a 32-bit code, 4 of them
// emitting a word. Flush moves the packer to its flush state, which writes one result word.
// Synchronous active-low reset clears the packer and control; the table is not cleared.
// A stall on out holds the packer at its next byte; in is stalled while an item is at work.
`include "huffman_code_bit_packer_unit_defines.svh"
module huffman_code_bit_packer_unit #(
  parameter int SYMBOLS      = hcbp_pkg::SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hcbp_pkg::hcbp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hcbp_pkg::hcbp_out_t out_data
);
  import hcbp_pkg::*;

  localparam int ADDR_W  = $clog2(SYMBOLS);
  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t          state_r;
  logic            accept;
  logic            sym_ok;
  logic            tbl_wr;
  logic            tbl_rd;
  hcbp_entry_t     wr_entry;
  hcbp_entry_t     rd_entry;
  hcbp_pk_ctrl_t   pk_ctrl;
  hcbp_pk_status_t pk_status;

  assign in_stall = (state_r != S_IDLE) || pk_status.busy;
  assign accept   = in_valid && !in_stall;
  assign sym_ok   = ({1'b0, in_data.symbol} < 9'(SYMBOLS));

  always_comb begin
    tbl_wr = 1'b0;
    tbl_rd = 1'b0;
    pk_ctrl.start_flush = 1'b0;
    unique case (in_data.cmd)
      CMD_LOAD:   tbl_wr = accept && sym_ok;
      CMD_ENCODE: tbl_rd = accept && sym_ok;
      CMD_FLUSH:  pk_ctrl.start_flush = accept;
      default: ;
    endcase
    wr_entry.code = in_data.code_bits;
    // clamp long codes to the supported length
    wr_entry.len  = (in_data.code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                            : in_data.code_length;
    pk_ctrl.start_enc = (state_r == S_READ);
    pk_ctrl.code      = rd_entry.code;
    pk_ctrl.len       = rd_entry.len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:  if (tbl_rd) state_r <= S_READ;
        S_READ:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  hcbp_table #(
    .SYMBOLS (SYMBOLS),
    .ADDR_W  (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (in_data.symbol[ADDR_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (tbl_rd),
    .rd_addr (in_data.symbol[ADDR_W-1:0]),
    .rd_data (rd_entry)
  );

  hcbp_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (pk_ctrl),
    .status    (pk_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `HCBP_ASSERT(a_read_pk_idle, clk, rst_n, (state_r == S_READ) |-> !pk_status.busy, "table read while packer busy")
  `HCBP_ASSERT(a_read_one_cycle, clk, rst_n, (state_r == S_READ) |=> (state_r == S_IDLE), "read state held")
  `HCBP_ASSERT(a_encode_reads, clk, rst_n, tbl_rd |=> (state_r == S_READ), "encode did not start a table read")

endmodule

// ===== tb/huffman_code_bit_packer_unit_tb.sv =====
// Self-checking testbench for huffman_code_bit_packer_unit: loads code tables, encodes, flushes.
// Predicts packed bytes in-line and checks every result word; depends on hcbp_pkg and the RTL.
module huffman_code_bit_packer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbp_pkg::*;

  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         MAX_LEN     = MAX_CODE_LEN_DEF;
  localparam int         RAND_WORDS  = 290;
  localparam int         CALM_TAIL   = 40;
  localparam int         HOLD_AFTER  = 60;
  localparam int         HOLD_CYCLES = 400;
  localparam int         TAIL_CYCLES = 16;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  hcbp_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  hcbp_out_t out_data;

  // stimulus side
  hcbp_in_t  word_q[$];
  bit        loaded_map[256];
  int        loaded_syms[$];
  int        gap_left    = 0;
  int        words_taken = 0;

  // receiver side
  int        stall_left = 0;
  int        hold_left  = 0;
  bit        hold_done  = 1'b0;

  // packer prediction
  logic [CODE_W-1:0]  code_mem[256];
  logic [LEN_W-1:0]   len_mem[256];
  logic [BYTE_W-1:0]  pend_byte = '0;
  int                 pend_fill = 0;
  logic [TOTAL_W-1:0] bit_sum   = '0;
  hcbp_out_t          expected_bytes[$];
  hcbp_out_t          want_res;
  int                 err_count = 0;

  huffman_code_bit_packer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic add_word(logic [1:0] cmd, int sym, logic [CODE_W-1:0] code, int len);
    hcbp_in_t w;
    w.cmd         = cmd;
    w.symbol      = sym[7:0];
    w.code_bits   = code;
    w.code_length = len[LEN_W-1:0];
    word_q.push_back(w);
    if (cmd == CMD_LOAD && !loaded_map[sym]) begin
      loaded_map[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  // Work out the result words caused by one accepted input word.
  function automatic void pack_word(hcbp_in_t w);
    hcbp_out_t res[4];
    int        cnt;
    int        n;
    logic [CODE_W-1:0] code;
    cnt = 0;
    case (w.cmd)
      CMD_LOAD: begin
        n = w.code_length;
        if (n > MAX_LEN) n = MAX_LEN;
        if (n > CODE_W) n = CODE_W;
        code_mem[w.symbol] = w.code_bits;
        len_mem[w.symbol]  = n[LEN_W-1:0];
      end
      CMD_ENCODE: begin
        code = code_mem[w.symbol];
        n    = len_mem[w.symbol];
        // shift the code in one bit at a time, MSB first
        for (int i = n - 1; i >= 0; i--) begin
          pend_byte[7 - pend_fill] = code[i];
          pend_fill++;
          if (bit_sum != '1) bit_sum++;
          if (pend_fill == 8) begin
            res[cnt] = '{out_byte: pend_byte, byte_valid: 1'b1, total_bits: bit_sum,
                         last: 1'b0};
            cnt++;
            pend_byte = '0;
            pend_fill = 0;
          end
        end
        for (int k = 0; k < cnt; k++) begin
          res[k].last = (k == cnt - 1);
          expected_bytes.push_back(res[k]);
        end
      end
      CMD_FLUSH: begin
        res[0] = '{out_byte: (pend_fill != 0) ? pend_byte : '0,
                   byte_valid: (pend_fill != 0), total_bits: bit_sum, last: 1'b1};
        expected_bytes.push_back(res[0]);
        pend_byte = '0;
        pend_fill = 0;
        bit_sum   = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      err_count++;
    end
  endtask

  // Driver: hold a stalled word, otherwise advance to the next one or idle for a burst.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        pack_word(in_data);
        words_taken <= words_taken + 1;
      end
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (word_q.size() != 0 &&
                   (word_q.size() < CALM_TAIL || $urandom_range(0, 5) != 0)) begin
        in_data  <= word_q.pop_front();
        in_valid <= 1'b1;
      end else if (word_q.size() != 0) begin
        gap_left <= $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random bursts, plus one long hold-off to back the block up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && words_taken >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (word_q.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, out_data);
        err_count++;
      end else begin
        want_res = expected_bytes.pop_front();
        check_field("out_byte", want_res.out_byte, out_data.out_byte);
        check_field("byte_valid", want_res.byte_valid, out_data.byte_valid);
        check_field("total_bits", want_res.total_bits, out_data.total_bits);
        check_field("last", want_res.last, out_data.last);
      end
    end
  end

  initial begin
    int r;
    int cnt;
    int sym;
    int len;

    // directed: empty flush, length extremes, saturating lengths, unused high code bits
    add_word(CMD_FLUSH, 0, '0, 0);
    add_word(CMD_LOAD, 0, 32'hFFFF_FFFF, 0);
    add_word(CMD_LOAD, 255, 32'hFFFF_FFFF, 32);
    add_word(CMD_LOAD, 1, 32'hA5A5_A5A5, 63);
    add_word(CMD_LOAD, 2, 32'h0000_0001, 1);
    add_word(CMD_LOAD, 3, 32'h0000_005A, 7);
    add_word(CMD_LOAD, 4, 32'h1234_5678, 33);
    add_word(CMD_LOAD, 128, 32'hFFFF_FF00, 8);
    add_word(CMD_ENCODE, 0, '0, 0);
    add_word(CMD_ENCODE, 2, '0, 0);
    add_word(CMD_FLUSH, 0, '0, 0);
    add_word(CMD_ENCODE, 255, '0, 0);
    add_word(CMD_ENCODE, 2, '0, 0);
    add_word(CMD_ENCODE, 255, '0, 0);
    add_word(CMD_ENCODE, 3, '0, 0);
    add_word(CMD_ENCODE, 1, '0, 0);
    add_word(CMD_SPARE, 255, 32'hFFFF_FFFF, 63);
    add_word(CMD_ENCODE, 128, '0, 0);
    add_word(CMD_ENCODE, 4, '0, 0);
    add_word(CMD_FLUSH, 0, '0, 0);
    add_word(CMD_LOAD, 127, 32'h0000_0015, 5);
    add_word(CMD_ENCODE, 127, '0, 0);
    add_word(CMD_FLUSH, 0, '0, 0);

    // random: mostly encodes of loaded symbols, with reloads, flushes and spare commands
    cnt = 0;
    while (cnt < RAND_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        sym = $urandom_range(0, 255);
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 12);
        add_word(CMD_LOAD, sym, $urandom, len);
        cnt++;
      end else if (r < 86) begin
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        add_word(CMD_ENCODE, sym, $urandom, $urandom_range(0, 63));
        cnt++;
      end else if (r < 95) begin
        add_word(CMD_FLUSH, $urandom_range(0, 255), $urandom, $urandom_range(0, 63));
        cnt++;
      end else begin
        add_word(CMD_SPARE, $urandom_range(0, 255), $urandom, $urandom_range(0, 63));
      end
    end
    add_word(CMD_FLUSH, 0, '0, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (word_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/hcbp_pkg.sv
sv/hcbp_table.sv
sv/hcbp_packer.sv
sv/huffman_code_bit_packer_unit.sv
tb/huffman_code_bit_packer_unit_tb.sv
